@@ rtl/core/rcd_pkg.sv @@
package rcd_pkg;

    localparam int PICKS_LIMIT = 8;
    localparam int POOL_LIMIT  = 99;

    localparam int SEED_W  = 64;
    localparam int BYTE_W  = 8;
    localparam int BALL_W  = 7;
    localparam int POS_W   = 3;
    localparam int MPICK_W = 4;
    localparam int EPICK_W = 3;
    localparam int CFG_W   = 7;
    localparam int IDX_W   = 2;

    typedef enum logic [IDX_W-1:0] {
        REG_MAIN_PICKS  = 2'd0,
        REG_MAIN_BALLS  = 2'd1,
        REG_EXTRA_PICKS = 2'd2,
        REG_EXTRA_BALLS = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PICK,
        S_DIV,
        S_SCAN,
        S_EMIT,
        S_ERR
    } t_state;

endpackage

@@ rtl/core/random_combination_draw.sv @@
// Random combination draw.
// Slave stream: one 64-bit seed per beat on s_axis_tdata. Byte k of the seed,
// little-endian, drives the k-th pick overall (main group first, then extra).
// Master stream: one beat per drawn number, each group in ascending order;
// tdata carries ball number and rank, tuser the extra-group and error flags,
// tlast marks the final beat of the draw. Bad settings give one error beat.
// Configuration: i_cfg_we writes register i_cfg_idx with i_cfg_data; write
// only while the block is idle.
// Operation: each pick runs a shift-subtract remainder unit, then scans the
// numbers already taken in its group, one per cycle, and inserts the new
// number in sorted place. Once its picks are done, each group streams out at
// one beat per cycle while the receiver accepts them.
// The seed port is ready only in the idle state. The last result sits in an
// output register, so the next seed is taken while it waits. When the
// receiver stalls, the sequencer holds until the output register frees.
// Reset loads the register defaults (6 of 49, no extra group) and idles.
module random_combination_draw (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] seed_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [6:0] ball_number, [9:7] position, [15:10] zero
    output logic [1:0]  m_axis_tuser,   // [0] in_extra_group, [1] error_flag
    output logic        m_axis_tlast,   // last_of_draw
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [6:0]  i_cfg_data
);
    import rcd_pkg::*;

    // configuration
    logic [MPICK_W-1:0] r_main_draws;
    logic [BALL_W-1:0]  r_main_pool;
    logic [EPICK_W-1:0] r_extra_draws;
    logic [BALL_W-1:0]  r_extra_pool;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_draws  <= MPICK_W'(6);
            r_main_pool   <= BALL_W'(49);
            r_extra_draws <= '0;
            r_extra_pool  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_MAIN_PICKS:  r_main_draws  <= i_cfg_data[MPICK_W-1:0];
                REG_MAIN_BALLS:  r_main_pool   <= i_cfg_data[BALL_W-1:0];
                REG_EXTRA_PICKS: r_extra_draws <= i_cfg_data[EPICK_W-1:0];
                REG_EXTRA_BALLS: r_extra_pool  <= i_cfg_data[BALL_W-1:0];
                default: ;
            endcase
        end
    end

    logic [MPICK_W:0] w_pick_sum;
    logic             w_bad;

    assign w_pick_sum = {1'b0, r_main_draws} + {2'b00, r_extra_draws};
    assign w_bad = (r_main_draws == '0)
                || (w_pick_sum > (MPICK_W+1)'(PICKS_LIMIT))
                || (r_main_pool > BALL_W'(POOL_LIMIT))
                || (r_extra_pool > BALL_W'(POOL_LIMIT))
                || (r_main_pool < {3'b000, r_main_draws})
                || ((r_extra_draws != '0) && (r_extra_pool < {4'b0000, r_extra_draws}));

    // sequencer state and datapath registers
    t_state             r_state, n_state;
    logic [SEED_W-1:0]  r_seed,  n_seed;
    logic [BALL_W-1:0]  r_left,  n_left;
    logic [MPICK_W-1:0] r_picks, n_picks;
    logic [MPICK_W-1:0] r_cnt,   n_cnt;
    logic               r_group, n_group;
    logic [BALL_W-1:0]  r_cand,  n_cand;
    logic [POS_W-1:0]   r_pos,   n_pos;
    logic [POS_W-1:0]   r_j,     n_j;
    logic [BALL_W-1:0]  r_taken [PICKS_LIMIT];
    logic [BALL_W-1:0]  n_taken [PICKS_LIMIT];

    logic               r_ovalid, n_ovalid;
    logic [BALL_W-1:0]  r_oball,  n_oball;
    logic [POS_W-1:0]   r_opos,   n_opos;
    logic               r_oextra, n_oextra;
    logic               r_oerr,   n_oerr;
    logic               r_olast,  n_olast;

    logic               w_div_start;
    logic               w_div_done;
    logic [BALL_W-1:0]  w_div_rem;
    logic               w_out_free;

    rcd_divmod u_divmod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_seed[BYTE_W-1:0]),
        .i_divisor  (r_left),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    assign w_div_start   = (r_state == S_PICK);
    assign w_out_free    = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_seed   = r_seed;
        n_left   = r_left;
        n_picks  = r_picks;
        n_cnt    = r_cnt;
        n_group  = r_group;
        n_cand   = r_cand;
        n_pos    = r_pos;
        n_j      = r_j;
        n_taken  = r_taken;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_oball  = r_oball;
        n_opos   = r_opos;
        n_oextra = r_oextra;
        n_oerr   = r_oerr;
        n_olast  = r_olast;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_seed = s_axis_tdata;
                    if (w_bad) begin
                        n_state = S_ERR;
                    end else begin
                        n_left  = r_main_pool;
                        n_picks = r_main_draws;
                        n_cnt   = '0;
                        n_group = 1'b0;
                        n_state = S_PICK;
                    end
                end
            end
            S_PICK: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_cand  = w_div_rem + BALL_W'(1);
                    n_pos   = '0;
                    n_j     = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if ({1'b0, r_j} == r_cnt) begin
                    // insert the new number in sorted place
                    for (int i = 0; i < PICKS_LIMIT; i++) begin
                        if (POS_W'(i) == r_pos) begin
                            n_taken[i] = r_cand;
                        end else if (POS_W'(i) > r_pos && i > 0) begin
                            n_taken[i] = r_taken[(i > 0) ? i - 1 : 0];
                        end
                    end
                    n_cnt  = r_cnt + MPICK_W'(1);
                    n_seed = r_seed >> BYTE_W;
                    n_left = r_left - BALL_W'(1);
                    n_j    = '0;
                    if (r_cnt + MPICK_W'(1) == r_picks) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_PICK;
                    end
                end else begin
                    // skip past every taken number at or below the candidate
                    if (r_taken[r_j] <= r_cand) begin
                        n_cand = r_cand + BALL_W'(1);
                        n_pos  = r_pos + POS_W'(1);
                    end
                    n_j = r_j + POS_W'(1);
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_oball  = r_taken[r_j];
                    n_opos   = r_j;
                    n_oextra = r_group;
                    n_oerr   = 1'b0;
                    n_olast  = 1'b0;
                    n_j      = r_j + POS_W'(1);
                    if ({1'b0, r_j} + MPICK_W'(1) == r_picks) begin
                        if (!r_group && r_extra_draws != '0) begin
                            n_group = 1'b1;
                            n_left  = r_extra_pool;
                            n_picks = {1'b0, r_extra_draws};
                            n_cnt   = '0;
                            n_state = S_PICK;
                        end else begin
                            n_olast = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_ERR: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_oball  = '0;
                    n_opos   = '0;
                    n_oextra = 1'b0;
                    n_oerr   = 1'b1;
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seed   <= n_seed;
        r_left   <= n_left;
        r_picks  <= n_picks;
        r_cnt    <= n_cnt;
        r_group  <= n_group;
        r_cand   <= n_cand;
        r_pos    <= n_pos;
        r_j      <= n_j;
        r_taken  <= n_taken;
        r_oball  <= n_oball;
        r_opos   <= n_opos;
        r_oextra <= n_oextra;
        r_oerr   <= n_oerr;
        r_olast  <= n_olast;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'b000000, r_opos, r_oball};
    assign m_axis_tuser  = {r_oerr, r_oextra};
    assign m_axis_tlast  = r_olast;

endmodule

@@ rtl/core/rcd_divmod.sv @@
module rcd_divmod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rcd_pkg::BYTE_W-1:0] i_dividend,
    input  logic [rcd_pkg::BALL_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [rcd_pkg::BALL_W-1:0] o_rem
);
    import rcd_pkg::*;

    logic              r_busy;
    logic [2:0]        r_step;
    logic              r_done;
    logic [BYTE_W-1:0] r_dvd;
    logic [BALL_W-1:0] r_rem;
    logic [BALL_W-1:0] r_dsr;
    logic [BYTE_W-1:0] w_trial;
    logic [BYTE_W-1:0] w_diff;
    logic              w_ge;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_dvd[BYTE_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dsr};
    assign w_diff  = w_trial - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[BYTE_W-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[BALL_W-1:0] : w_trial[BALL_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
